FILE: rtl/ted_pkg.sv
// shared types and constants for the triangle edge dedup table
// no dependencies
package ted_pkg;

  localparam int NodeW      = 10;
  localparam int EdgeW      = 12;
  localparam int NodeCount  = 1024;
  localparam int MaxDegree  = 8;
  localparam int MaxEdges   = 4096;
  localparam int SlotW      = $clog2(MaxDegree);
  localparam int FillW      = $clog2(MaxDegree + 1);
  localparam int CountW     = $clog2(MaxEdges + 1);
  localparam int EntryW     = NodeW + EdgeW;
  localparam int RowBits    = MaxDegree * EntryW;
  localparam int MemW       = FillW + RowBits;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_RESOLVE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       rd;
    logic       resolve;
    logic [1:0] sel;
  } ctrl_t;

endpackage

FILE: rtl/triangle_edge_dedup_table.sv
// top level of the triangle edge dedup table: controller plus datapath
// depends on ted_pkg, ted_ctrl, ted_datapath
// each edge of a triangle goes through read, wait and resolve steps, then the result waits for output
// one triangle at a time: s_axis_tready stays low until the result has been taken
// reset: edge counter clears at once, then a clear pass zeroes every neighbour row
// with s_axis_tready low
module triangle_edge_dedup_table import ted_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // node_a, node_b, node_c
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // edge_first, edge_second, edge_third, new_first,
                                     // new_second, new_third, table_full
);

  ctrl_t               ctrl;
  logic [3*EdgeW-1:0]  edges;
  logic [2:0]          fresh;
  logic                full;
  logic                clear_last;

  ted_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .clear_last_i(clear_last),
    .ctrl_o      (ctrl)
  );

  ted_datapath u_dp (
    .clk_i, .rst_ni,
    .ctrl_i      (ctrl),
    .node_a_i    (s_axis_tdata[9:0]),
    .node_b_i    (s_axis_tdata[19:10]),
    .node_c_i    (s_axis_tdata[29:20]),
    .edges_o     (edges),
    .fresh_o     (fresh),
    .full_o      (full),
    .clear_last_o(clear_last)
  );

  assign m_axis_tdata = {full, fresh, edges};

endmodule

FILE: rtl/ted_datapath.sv
// datapath: per-node neighbour rows with fill counts, edge counter and result registers
// depends on ted_pkg
module ted_datapath import ted_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  logic [NodeW-1:0]     node_a_i,
  input  logic [NodeW-1:0]     node_b_i,
  input  logic [NodeW-1:0]     node_c_i,
  output logic [3*EdgeW-1:0]   edges_o,
  output logic [2:0]           fresh_o,
  output logic                 full_o,
  output logic                 clear_last_o
);

  // row layout: fill count on top, slot k at bits k*EntryW, tag above index
  logic [MemW-1:0]        row_mem [NodeCount];
  logic [MemW-1:0]        row_q;
  logic [MemW-1:0]        wr_data;
  logic [NodeW-1:0]       wr_addr;
  logic                   wr_en;
  logic [NodeW-1:0]       clr_q;
  logic [FillW-1:0]       rfill;
  logic [CountW-1:0]      count_q;
  logic [NodeW-1:0]       na_q, nb_q, nc_q;
  logic [EdgeW-1:0]       e_q [3];
  logic [2:0]             fresh_q;
  logic                   full_q;
  logic [NodeW-1:0]       p, q, key, tag;
  logic                   hit, ok;
  logic [EdgeW-1:0]       hidx;

  always_comb begin
    case (ctrl_i.sel)
      2'd0:    begin p = na_q; q = nb_q; end
      2'd1:    begin p = nc_q; q = na_q; end
      default: begin p = nb_q; q = nc_q; end
    endcase
    key = (p > q) ? p : q;
    tag = (p > q) ? q : p;
    rfill = row_q[RowBits +: FillW];
    hit  = 1'b0;
    hidx = '0;
    for (int k = MaxDegree - 1; k >= 0; k--) begin
      if (FillW'(k) < rfill && row_q[k*EntryW + EdgeW +: NodeW] == tag) begin
        hit  = 1'b1;
        hidx = row_q[k*EntryW +: EdgeW];
      end
    end
    ok = (rfill < FillW'(MaxDegree)) && (count_q < CountW'(MaxEdges));
    wr_data = row_q;
    wr_data[RowBits +: FillW] = rfill + FillW'(1);
    for (int k = 0; k < MaxDegree; k++) begin
      if (FillW'(k) == rfill) wr_data[k*EntryW +: EntryW] = {tag, count_q[EdgeW-1:0]};
    end
    wr_addr = key;
    wr_en   = ctrl_i.resolve && !hit && ok;
    if (ctrl_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      na_q <= node_a_i;
      nb_q <= node_b_i;
      nc_q <= node_c_i;
    end
    if (wr_en) row_mem[wr_addr] <= wr_data;
    if (ctrl_i.rd) row_q <= row_mem[key];
    if (ctrl_i.resolve) begin
      e_q[ctrl_i.sel] <= hit ? hidx : (ok ? count_q[EdgeW-1:0] : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      count_q <= '0;
      fresh_q <= '0;
      full_q  <= 1'b0;
    end else begin
      if (ctrl_i.clear) clr_q <= clr_q + NodeW'(1);
      if (ctrl_i.load) begin
        fresh_q <= '0;
        full_q  <= 1'b0;
      end
      if (ctrl_i.resolve) begin
        fresh_q[ctrl_i.sel] <= !hit && ok;
        if (!hit && !ok) full_q <= 1'b1;
        if (!hit && ok) count_q <= count_q + CountW'(1);
      end
    end
  end

  assign edges_o      = {e_q[2], e_q[1], e_q[0]};
  assign fresh_o      = fresh_q;
  assign full_o       = full_q;
  assign clear_last_o = (clr_q == NodeW'(NodeCount - 1));

endmodule

FILE: rtl/ted_ctrl.sv
// controller: clears the rows after reset, then walks the three local edges
// through read, wait and resolve steps; depends on ted_pkg
module ted_ctrl import ted_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  logic  clear_last_i,
  output ctrl_t ctrl_o
);

  state_e     state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_CLEAR:   if (clear_last_i) state_d = ST_IDLE;
      ST_IDLE:    if (in_valid_i) begin state_d = ST_READ; sel_d = 2'd0; end
      ST_READ:    state_d = ST_WAIT;
      ST_WAIT:    state_d = ST_RESOLVE;
      ST_RESOLVE: begin
        if (sel_q == 2'd2) state_d = ST_OUT;
        else begin
          state_d = ST_READ;
          sel_d   = sel_q + 2'd1;
        end
      end
      ST_OUT:     if (out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    out_valid_o    = (state_q == ST_OUT);
    ctrl_o.clear   = (state_q == ST_CLEAR);
    ctrl_o.load    = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.rd      = (state_q == ST_READ);
    ctrl_o.resolve = (state_q == ST_RESOLVE);
    ctrl_o.sel     = sel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sel_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule
